/* rtl/core/modular_matrix_power_unit_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the modular matrix power unit
// Shared concurrent assertion forms, sampled on i_clk, muted during reset.
// ----------------------------------------------------------------------------
`ifndef MODULAR_MATRIX_POWER_UNIT_ASSERT_SVH
`define MODULAR_MATRIX_POWER_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MMP_ASSERT_HOLD(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MMP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/mmp_pkg.sv */
// ----------------------------------------------------------------------------
// Modular matrix power package
// Shared constants, types and address helper for the matrix power unit.
// ----------------------------------------------------------------------------
`default_nettype none

package mmp_pkg;

    localparam int MAX_N  = 8;
    localparam int CELLS  = MAX_N * MAX_N;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int DATA_W = 30;
    localparam int SIZE_W = 4;
    localparam int CNT_W  = ADDR_W + 1;

    localparam logic [DATA_W-1:0] MODULUS  = 30'd1000000007;
    localparam logic [31:0]       MOD_X1   = 32'd1000000007;
    localparam logic [31:0]       MOD_X2   = 32'd2000000014;

    // Barrett factor floor(2^60 / modulus), fits in 31 bits.
    localparam logic [63:0] BARRETT_MU64 = 64'h1000_0000_0000_0000 / 64'd1000000007;
    localparam logic [30:0] BARRETT_MU   = BARRETT_MU64[30:0];

    // Configuration register indexes.
    localparam logic [0:0] REG_MATRIX_SIZE = 1'b0;
    localparam logic [0:0] REG_EXPONENT    = 1'b1;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_COPY,
        ST_DRAIN,
        ST_NORM,
        ST_BIT,
        ST_MREQ,
        ST_MRUN,
        ST_MWAIT,
        ST_OREQ,
        ST_OLOAD,
        ST_OWAIT
    } t_state;

    typedef enum logic [1:0] {
        MD_INIT,
        MD_SQUARE,
        MD_BASE
    } t_mode;

    typedef enum logic [1:0] {
        MS_IDLE,
        MS_QUOT,
        MS_BACK,
        MS_FIX
    } t_mul_state;

    typedef struct packed {
        logic              start;
        logic [DATA_W-1:0] a;
        logic [DATA_W-1:0] b;
    } t_mul_req;

    typedef struct packed {
        logic              done;
        logic [DATA_W-1:0] result;
    } t_mul_rsp;

    // Flat row-major address of (row, col) in an n-by-n matrix.
    function automatic logic [ADDR_W-1:0] mmp_addr(input logic [2:0] row,
                                                   input logic [2:0] col,
                                                   input logic [SIZE_W-1:0] n);
        logic [6:0] full;
        full = ({4'b0, row} * {3'b0, n}) + {4'b0, col};
        return full[ADDR_W-1:0];
    endfunction

endpackage

`default_nettype wire

/* rtl/core/mmp_modmul.sv */
// ----------------------------------------------------------------------------
// Shared modular multiplier
// One 31x31 multiplier reused for the product and both Barrett steps.
// ----------------------------------------------------------------------------
`default_nettype none

`include "modular_matrix_power_unit_assert.svh"

module mmp_modmul (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire mmp_pkg::t_mul_req i_req,
    output mmp_pkg::t_mul_rsp      o_rsp
);

    mmp_pkg::t_mul_state r_state, n_state;
    logic [61:0] r_mp;
    logic [31:0] r_plo;
    logic [29:0] r_res;
    logic        r_done;

    logic [30:0] mul_x, mul_y;
    logic [61:0] mul_p;
    logic [31:0] diff, fixed;

    // The one multiplier of the unit.
    assign mul_p = {31'b0, mul_x} * {31'b0, mul_y};

    // Next state: product, quotient estimate, back multiply, correction.
    always_comb begin
        n_state = r_state;
        case (r_state)
            mmp_pkg::MS_IDLE: if (i_req.start) n_state = mmp_pkg::MS_QUOT;
            mmp_pkg::MS_QUOT: n_state = mmp_pkg::MS_BACK;
            mmp_pkg::MS_BACK: n_state = mmp_pkg::MS_FIX;
            mmp_pkg::MS_FIX:  n_state = mmp_pkg::MS_IDLE;
            default:          n_state = mmp_pkg::MS_IDLE;
        endcase
    end

    // Multiplier operand selection per step.
    always_comb begin
        mul_x = '0;
        mul_y = '0;
        case (r_state)
            mmp_pkg::MS_IDLE: begin
                mul_x = {1'b0, i_req.a};
                mul_y = {1'b0, i_req.b};
            end
            mmp_pkg::MS_QUOT: begin
                mul_x = r_mp[59:29];
                mul_y = mmp_pkg::BARRETT_MU;
            end
            mmp_pkg::MS_BACK: begin
                mul_x = r_mp[61:31];
                mul_y = {1'b0, mmp_pkg::MODULUS};
            end
            default: begin
                mul_x = '0;
                mul_y = '0;
            end
        endcase
    end

    // The Barrett remainder is below three moduli; subtract up to two.
    always_comb begin
        diff = r_plo - r_mp[31:0];
        if (diff >= mmp_pkg::MOD_X2) begin
            fixed = diff - mmp_pkg::MOD_X2;
        end else if (diff >= mmp_pkg::MOD_X1) begin
            fixed = diff - mmp_pkg::MOD_X1;
        end else begin
            fixed = diff;
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mmp_pkg::MS_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == mmp_pkg::MS_FIX);
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        case (r_state)
            mmp_pkg::MS_IDLE: if (i_req.start) r_mp <= mul_p;
            mmp_pkg::MS_QUOT: begin
                r_plo <= r_mp[31:0];
                r_mp  <= mul_p;
            end
            mmp_pkg::MS_BACK: r_mp <= mul_p;
            mmp_pkg::MS_FIX:  r_res <= fixed[29:0];
            default: ;
        endcase
    end

    assign o_rsp.done   = r_done;
    assign o_rsp.result = r_res;

    `MMP_ASSERT_HOLD(a_start_when_idle, i_req.start, r_state == mmp_pkg::MS_IDLE, "start while busy")
    `MMP_ASSERT_HOLD(a_result_reduced, r_done, r_res < mmp_pkg::MODULUS, "result not reduced")
    `MMP_ASSERT_NEXT(a_done_after_fix, r_state == mmp_pkg::MS_FIX, r_done, "missing done pulse")

endmodule

`default_nettype wire

/* rtl/core/modular_matrix_power_unit.sv */
// ----------------------------------------------------------------------------
// Modular matrix power unit
// Raises a loaded N-by-N matrix to a power modulo 1000000007 by binary
// exponentiation, with one shared modular multiplier under a sequencer.
// ----------------------------------------------------------------------------
// Each multiply-accumulate goes through the shared modular multiplier; a job
// runs (bit length - 1 + set bits below the top) matrix products, each one
// followed by a copy into the work store, after an exponent scan and an
// initial copy of the loaded matrix. Each result is read, registered and
// held until taken before the next one is fetched. The input is not
// ready from the last beat until all results are taken. Synchronous
// active-low reset; the matrix stores are not cleared.
`default_nettype none

`include "modular_matrix_power_unit_assert.svh"

module modular_matrix_power_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Configuration write port.
    input  wire logic        i_cfg_wr_en,
    input  wire logic [0:0]  i_cfg_addr,
    input  wire logic [29:0] i_cfg_wdata,
    // Input stream.
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [31:0] i_s_tdata,   // [29:0] element
    input  wire logic        i_s_tlast,
    // Output stream.
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [31:0]      o_m_tdata,   // [29:0] result_element
    output logic             o_m_tlast
);

    mmp_pkg::t_state r_state, n_state;
    mmp_pkg::t_mode  r_mode;

    logic [3:0]  r_msize;
    logic [29:0] r_exponent;
    logic [6:0]  r_load_cnt;
    logic        r_out_valid;
    logic        r_cpy_pend;

    logic [3:0]  r_n;
    logic [5:0]  r_last_idx;
    logic [5:0]  r_idx, r_cpy_addr;
    logic        r_ident;
    logic [29:0] r_exp;
    logic [4:0]  r_left;
    logic [2:0]  r_i, r_j, r_t;
    logic [29:0] r_acc;
    logic [29:0] r_out_data;
    logic        r_out_last;

    logic [29:0] base_mem [mmp_pkg::CELLS];
    logic [29:0] work_mem [mmp_pkg::CELLS];
    logic [29:0] prod_mem [mmp_pkg::CELLS];
    logic [29:0] r_base_q, r_work_qa, r_work_qb, r_prod_q;

    logic [3:0]  n_cur;
    logic [7:0]  sq_cur;
    logic [6:0]  cells_cur;
    logic        s_acc, base_we, prod_we, mul_start;
    logic [29:0] elem_red, cpy_data;
    logic [5:0]  addr_it, addr_tj, addr_ij, work_a_addr, base_addr;
    logic        i_last, j_last, t_last;
    logic [30:0] acc_sum;
    logic [29:0] acc_red;

    mmp_pkg::t_mul_req mul_req;
    mmp_pkg::t_mul_rsp mul_rsp;

    // Size in use, clamped into 1..MAX_N, and its cell count.
    always_comb begin
        if (r_msize == 4'd0) begin
            n_cur = 4'd1;
        end else if (r_msize > 4'(mmp_pkg::MAX_N)) begin
            n_cur = 4'(mmp_pkg::MAX_N);
        end else begin
            n_cur = r_msize;
        end
        sq_cur    = {4'b0, n_cur} * {4'b0, n_cur};
        cells_cur = sq_cur[6:0];
    end

    assign s_acc    = i_s_tvalid && o_s_tready;
    assign elem_red = (i_s_tdata[29:0] >= mmp_pkg::MODULUS)
                    ? i_s_tdata[29:0] - mmp_pkg::MODULUS : i_s_tdata[29:0];

    assign addr_it = mmp_pkg::mmp_addr(r_i, r_t, r_n);
    assign addr_tj = mmp_pkg::mmp_addr(r_t, r_j, r_n);
    assign addr_ij = mmp_pkg::mmp_addr(r_i, r_j, r_n);
    assign i_last  = ({1'b0, r_i} == (r_n - 4'd1));
    assign j_last  = ({1'b0, r_j} == (r_n - 4'd1));
    assign t_last  = ({1'b0, r_t} == (r_n - 4'd1));

    // Modular accumulate of the multiplier result.
    assign acc_sum = {1'b0, r_acc} + {1'b0, mul_rsp.result};
    assign acc_red = (acc_sum >= {1'b0, mmp_pkg::MODULUS})
                   ? 30'(acc_sum - {1'b0, mmp_pkg::MODULUS}) : acc_sum[29:0];

    // Next state of the sequencer.
    always_comb begin
        n_state = r_state;
        case (r_state)
            mmp_pkg::ST_LOAD: begin
                if (s_acc && i_s_tlast) begin
                    n_state = (r_exponent == 30'd0) ? mmp_pkg::ST_OREQ : mmp_pkg::ST_COPY;
                end
            end
            mmp_pkg::ST_COPY: if (r_idx == r_last_idx) n_state = mmp_pkg::ST_DRAIN;
            mmp_pkg::ST_DRAIN: begin
                case (r_mode)
                    mmp_pkg::MD_INIT:   n_state = mmp_pkg::ST_NORM;
                    mmp_pkg::MD_SQUARE: n_state = r_exp[29] ? mmp_pkg::ST_MREQ
                                                            : mmp_pkg::ST_BIT;
                    default:            n_state = mmp_pkg::ST_BIT;
                endcase
            end
            mmp_pkg::ST_NORM: if (r_exp[29]) n_state = mmp_pkg::ST_BIT;
            mmp_pkg::ST_BIT:  n_state = (r_left == 5'd0) ? mmp_pkg::ST_OREQ : mmp_pkg::ST_MREQ;
            mmp_pkg::ST_MREQ: n_state = mmp_pkg::ST_MRUN;
            mmp_pkg::ST_MRUN: n_state = mmp_pkg::ST_MWAIT;
            mmp_pkg::ST_MWAIT: begin
                if (mul_rsp.done) begin
                    n_state = (t_last && j_last && i_last) ? mmp_pkg::ST_COPY
                                                           : mmp_pkg::ST_MREQ;
                end
            end
            mmp_pkg::ST_OREQ:  n_state = mmp_pkg::ST_OLOAD;
            mmp_pkg::ST_OLOAD: n_state = mmp_pkg::ST_OWAIT;
            mmp_pkg::ST_OWAIT: begin
                if (i_m_tready) begin
                    n_state = r_out_last ? mmp_pkg::ST_LOAD : mmp_pkg::ST_OREQ;
                end
            end
            default: n_state = mmp_pkg::ST_LOAD;
        endcase
    end

    // Sequencer outputs: handshake, memory enables and addresses.
    always_comb begin
        o_s_tready  = (r_state == mmp_pkg::ST_LOAD);
        base_we     = s_acc && (r_load_cnt < cells_cur);
        prod_we     = (r_state == mmp_pkg::ST_MWAIT) && mul_rsp.done && t_last;
        mul_start   = (r_state == mmp_pkg::ST_MRUN);
        work_a_addr = (r_state == mmp_pkg::ST_OREQ) ? addr_ij : addr_it;
        base_addr   = (r_state == mmp_pkg::ST_COPY) ? r_idx : addr_tj;
        cpy_data    = (r_mode == mmp_pkg::MD_INIT) ? r_base_q : r_prod_q;
    end

    assign mul_req.start = mul_start;
    assign mul_req.a     = r_work_qa;
    assign mul_req.b     = (r_mode == mmp_pkg::MD_BASE) ? r_base_q : r_work_qb;

    mmp_modmul u_modmul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mul_req),
        .o_rsp   (mul_rsp)
    );

    // Matrix stores with registered reads.
    always_ff @(posedge i_clk) begin
        if (base_we) base_mem[r_load_cnt[5:0]] <= elem_red;
        r_base_q <= base_mem[base_addr];
    end

    always_ff @(posedge i_clk) begin
        if (r_cpy_pend) work_mem[r_cpy_addr] <= cpy_data;
        r_work_qa <= work_mem[work_a_addr];
        r_work_qb <= work_mem[addr_tj];
    end

    always_ff @(posedge i_clk) begin
        if (prod_we) prod_mem[addr_ij] <= acc_red;
        r_prod_q <= prod_mem[r_idx];
    end

    // Control registers and configuration.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mmp_pkg::ST_LOAD;
            r_msize     <= 4'd1;
            r_exponent  <= 30'd1;
            r_load_cnt  <= '0;
            r_out_valid <= 1'b0;
            r_cpy_pend  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_cpy_pend <= (r_state == mmp_pkg::ST_COPY);
            if (i_cfg_wr_en) begin
                case (i_cfg_addr)
                    mmp_pkg::REG_MATRIX_SIZE: r_msize    <= i_cfg_wdata[3:0];
                    mmp_pkg::REG_EXPONENT:    r_exponent <= i_cfg_wdata;
                    default: ;
                endcase
            end
            if (s_acc) begin
                if (i_s_tlast) begin
                    r_load_cnt <= '0;
                end else if (base_we) begin
                    r_load_cnt <= r_load_cnt + 7'd1;
                end
            end
            if (r_state == mmp_pkg::ST_OLOAD) begin
                r_out_valid <= 1'b1;
            end else if (r_state == mmp_pkg::ST_OWAIT && i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Sequencer datapath registers.
    always_ff @(posedge i_clk) begin
        case (r_state)
            mmp_pkg::ST_LOAD: begin
                if (s_acc && i_s_tlast) begin
                    r_n        <= n_cur;
                    r_last_idx <= sq_cur[5:0] - 6'd1;
                    r_ident    <= (r_exponent == 30'd0);
                    r_exp      <= r_exponent;
                    r_left     <= 5'd30;
                    r_mode     <= mmp_pkg::MD_INIT;
                    r_idx      <= '0;
                    r_i        <= '0;
                    r_j        <= '0;
                end
            end
            mmp_pkg::ST_COPY: begin
                r_idx      <= r_idx + 6'd1;
                r_cpy_addr <= r_idx;
            end
            mmp_pkg::ST_DRAIN: begin
                if (r_mode == mmp_pkg::MD_SQUARE && r_exp[29]) begin
                    r_mode <= mmp_pkg::MD_BASE;
                    r_i    <= '0;
                    r_j    <= '0;
                    r_t    <= '0;
                    r_acc  <= '0;
                end else if (r_mode != mmp_pkg::MD_INIT) begin
                    r_exp  <= {r_exp[28:0], 1'b0};
                    r_left <= r_left - 5'd1;
                end
            end
            mmp_pkg::ST_NORM: begin
                r_exp  <= {r_exp[28:0], 1'b0};
                r_left <= r_left - 5'd1;
            end
            mmp_pkg::ST_BIT: begin
                r_i <= '0;
                r_j <= '0;
                if (r_left != 5'd0) begin
                    r_mode <= mmp_pkg::MD_SQUARE;
                    r_t    <= '0;
                    r_acc  <= '0;
                end
            end
            mmp_pkg::ST_MWAIT: begin
                if (mul_rsp.done) begin
                    r_idx <= '0;
                    if (t_last) begin
                        r_t   <= '0;
                        r_acc <= '0;
                        if (j_last) begin
                            r_j <= '0;
                            r_i <= i_last ? 3'd0 : r_i + 3'd1;
                        end else begin
                            r_j <= r_j + 3'd1;
                        end
                    end else begin
                        r_t   <= r_t + 3'd1;
                        r_acc <= acc_red;
                    end
                end
            end
            mmp_pkg::ST_OLOAD: begin
                if (r_ident) begin
                    r_out_data <= (r_i == r_j) ? 30'd1 : 30'd0;
                end else begin
                    r_out_data <= r_work_qa;
                end
                r_out_last <= i_last && j_last;
            end
            mmp_pkg::ST_OWAIT: begin
                if (i_m_tready) begin
                    if (j_last) begin
                        r_j <= '0;
                        r_i <= r_i + 3'd1;
                    end else begin
                        r_j <= r_j + 3'd1;
                    end
                end
            end
            default: ;
        endcase
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {2'b00, r_out_data};
    assign o_m_tlast  = r_out_last;

    `MMP_ASSERT_HOLD(a_no_input_while_output, r_out_valid, !o_s_tready, "input ready during output")
    `MMP_ASSERT_HOLD(a_acc_reduced, r_state == mmp_pkg::ST_MWAIT, r_acc < mmp_pkg::MODULUS, "accumulator not reduced")
    `MMP_ASSERT_HOLD(a_load_bounded, 1'b1, r_load_cnt <= 7'(mmp_pkg::CELLS), "load count overflow")

endmodule

`default_nettype wire
